// ----- design/rbvm_pkg.sv -----
package rbvm_pkg;

  // Grid geometry. The map is addressed as (x*MAX_DIM + y)*MAX_DIM + z, which for a
  // power-of-two MAX_DIM is the plain concatenation of the three coordinates.
  localparam int MAX_DIM   = 64;
  localparam int COORD_W   = $clog2(MAX_DIM);
  localparam int ADDR_W    = 3 * COORD_W;
  localparam int MAX_CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int DIM_W     = 7;
  localparam int VEL_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
  localparam logic [DIM_W-1:0] DIM_MAX   = 7'd64;

  // Request codes.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_APPLY = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [VEL_W-1:0]   vel_t;

  typedef struct packed {
    logic   req_type;
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;
    logic   open_cell;
    vel_t   vel_x_in;
    vel_t   vel_y_in;
    vel_t   vel_z_in;
  } in_item_t;

  typedef struct packed {
    vel_t       vel_x_out;
    vel_t       vel_y_out;
    vel_t       vel_z_out;
    logic [2:0] zeroed_mask;
    logic       bad_coord;
  } out_item_t;

  // Read and write requests from the control logic to the map.
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    logic  wr_data;
    logic  rd_en;
    addr_t rd_addr_c;
    addr_t rd_addr_x;
    addr_t rd_addr_y;
    addr_t rd_addr_z;
  } map_req_t;

  function automatic addr_t cell_addr(coord_t x, coord_t y, coord_t z);
    return {x, y, z};
  endfunction

  // Dimension registers above the largest grid are saturated.
  function automatic dim_t eff_dim(dim_t d);
    return (d > DIM_MAX) ? DIM_MAX : d;
  endfunction

endpackage

// ----- design/rbvm_map.sv -----
// Open/solid map held as four identical one-bit memories, so that a cell and its
// three forward neighbours can be read in the same cycle. Every write goes to all
// four copies. Read data is registered and holds until the next read.
module rbvm_map (
  input  logic                clk,
  input  rbvm_pkg::map_req_t  req,
  output logic [3:0]          rd_data
);

  logic map_c [rbvm_pkg::MAX_CELLS];
  logic map_x [rbvm_pkg::MAX_CELLS];
  logic map_y [rbvm_pkg::MAX_CELLS];
  logic map_z [rbvm_pkg::MAX_CELLS];

  logic rd_c_r;
  logic rd_x_r;
  logic rd_y_r;
  logic rd_z_r;

  // Copy read at the cell itself.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      map_c[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_c_r <= map_c[req.rd_addr_c];
    end
  end

  // Copy read at the +x neighbour.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      map_x[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_x_r <= map_x[req.rd_addr_x];
    end
  end

  // Copy read at the +y neighbour.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      map_y[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_y_r <= map_y[req.rd_addr_y];
    end
  end

  // Copy read at the +z neighbour.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      map_z[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_z_r <= map_z[req.rd_addr_z];
    end
  end

  assign rd_data = {rd_z_r, rd_y_r, rd_x_r, rd_c_r};

endmodule

// ----- design/rigid_boundary_velocity_mask.sv -----
// Rigid-boundary velocity mask. Load items write one open/solid bit of a grid of up
// to 64 x 64 x 64 cells; apply items return their three velocity words with each
// component forced to zero where the cell or its forward neighbour along that axis
// is solid, except on the grid's last plane along that axis. Coordinates outside
// the size set in dim_x, dim_y and dim_z give bad_coord, drop a load and pass the
// velocities of an apply unchanged. The block takes one item every clock cycle while
// the result channel is not stalled; each result passes through the registered map
// read and then the output register. The map is held in four replicated one-bit
// memories so the four reads of an apply happen in the same cycle. The map has
// no clearing pass; every cell must be loaded before an apply reads it. The
// configuration port is always ready and may be written only while the block is
// idle.
module rigid_boundary_velocity_mask (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rbvm_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rbvm_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbvm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbvm_pkg::DIM_W-1:0]          cfg_data
);

  rbvm_pkg::dim_t dim_x_r;
  rbvm_pkg::dim_t dim_y_r;
  rbvm_pkg::dim_t dim_z_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r <= rbvm_pkg::DIM_RESET;
      dim_y_r <= rbvm_pkg::DIM_RESET;
      dim_z_r <= rbvm_pkg::DIM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rbvm_pkg::REG_DIM_X: dim_x_r <= cfg_data;
        rbvm_pkg::REG_DIM_Y: dim_y_r <= cfg_data;
        rbvm_pkg::REG_DIM_Z: dim_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address stage: coordinate check and the four map addresses.
  rbvm_pkg::dim_t     nx;
  rbvm_pkg::dim_t     ny;
  rbvm_pkg::dim_t     nz;
  logic               bad;
  logic [2:0]         has_nbr;
  logic               in_accept;
  rbvm_pkg::map_req_t map_req;
  logic [3:0]         map_rd;

  assign nx = rbvm_pkg::eff_dim(dim_x_r);
  assign ny = rbvm_pkg::eff_dim(dim_y_r);
  assign nz = rbvm_pkg::eff_dim(dim_z_r);

  assign bad = ({1'b0, in_item.coord_x} >= nx) || ({1'b0, in_item.coord_y} >= ny) ||
               ({1'b0, in_item.coord_z} >= nz);

  // A component can be zeroed only when its forward neighbour lies inside the grid.
  assign has_nbr[0] = ({1'b0, in_item.coord_x} + 7'd1) < nx;
  assign has_nbr[1] = ({1'b0, in_item.coord_y} + 7'd1) < ny;
  assign has_nbr[2] = ({1'b0, in_item.coord_z} + 7'd1) < nz;

  assign in_accept = in_valid && in_ready;

  always_comb begin
    map_req.wr_en     = in_accept && (in_item.req_type == rbvm_pkg::REQ_LOAD) && !bad;
    map_req.wr_addr   = rbvm_pkg::cell_addr(in_item.coord_x, in_item.coord_y,
                                            in_item.coord_z);
    map_req.wr_data   = in_item.open_cell;
    map_req.rd_en     = in_accept && (in_item.req_type == rbvm_pkg::REQ_APPLY) && !bad;
    map_req.rd_addr_c = map_req.wr_addr;
    map_req.rd_addr_x = rbvm_pkg::cell_addr(in_item.coord_x + 6'd1, in_item.coord_y,
                                            in_item.coord_z);
    map_req.rd_addr_y = rbvm_pkg::cell_addr(in_item.coord_x, in_item.coord_y + 6'd1,
                                            in_item.coord_z);
    map_req.rd_addr_z = rbvm_pkg::cell_addr(in_item.coord_x, in_item.coord_y,
                                            in_item.coord_z + 6'd1);
  end

  rbvm_map u_map (
    .clk     (clk),
    .req     (map_req),
    .rd_data (map_rd)
  );

  // Read stage: the item waits here while its map bits are read.
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic                s1_req_r;
  logic                s1_bad_r;
  logic [2:0]          s1_has_nbr_r;
  rbvm_pkg::vel_t      s1_vx_r;
  rbvm_pkg::vel_t      s1_vy_r;
  rbvm_pkg::vel_t      s1_vz_r;
  logic                s1_adv;
  logic                out_valid_r;
  logic                out_valid_nxt;
  rbvm_pkg::out_item_t out_item_r;
  rbvm_pkg::out_item_t res;
  logic                here;
  logic [2:0]          zero;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  assign s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r     <= in_item.req_type;
      s1_bad_r     <= bad;
      s1_has_nbr_r <= has_nbr;
      s1_vx_r      <= in_item.vel_x_in;
      s1_vy_r      <= in_item.vel_y_in;
      s1_vz_r      <= in_item.vel_z_in;
    end
  end

  // Masking: a component is zeroed when it has a neighbour and either cell is solid.
  assign here    = map_rd[0];
  assign zero[0] = s1_has_nbr_r[0] && !(here && map_rd[1]);
  assign zero[1] = s1_has_nbr_r[1] && !(here && map_rd[2]);
  assign zero[2] = s1_has_nbr_r[2] && !(here && map_rd[3]);

  always_comb begin
    res.bad_coord = s1_bad_r;
    if (s1_req_r == rbvm_pkg::REQ_LOAD) begin
      res.vel_x_out   = '0;
      res.vel_y_out   = '0;
      res.vel_z_out   = '0;
      res.zeroed_mask = 3'b000;
    end else if (s1_bad_r) begin
      res.vel_x_out   = s1_vx_r;
      res.vel_y_out   = s1_vy_r;
      res.vel_z_out   = s1_vz_r;
      res.zeroed_mask = 3'b000;
    end else begin
      res.vel_x_out   = zero[0] ? '0 : s1_vx_r;
      res.vel_y_out   = zero[1] ? '0 : s1_vy_r;
      res.vel_z_out   = zero[2] ? '0 : s1_vz_r;
      res.zeroed_mask = zero;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- design/rbvm_checker.sv -----
// Port-level checks on the result channel.
module rbvm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input rbvm_pkg::out_item_t out_item
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("stalled result changed");

  // Every component flagged as zeroed carries zero bits.
  a_zero_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_item.zeroed_mask[0] || out_item.vel_x_out == '0) &&
                  (!out_item.zeroed_mask[1] || out_item.vel_y_out == '0) &&
                  (!out_item.zeroed_mask[2] || out_item.vel_z_out == '0))
    else $error("zeroed component is not zero");

  // An item with bad coordinates never has a component zeroed.
  a_bad_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.bad_coord |-> out_item.zeroed_mask == 3'b000)
    else $error("bad coordinates with a zeroed component");

endmodule

bind rigid_boundary_velocity_mask rbvm_checker u_rbvm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ----- verif/rigid_boundary_velocity_mask_tb.sv -----
module rigid_boundary_velocity_mask_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES     = 300;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 130;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    rbvm_pkg::in_item_t             item;
    bit                             typed;
    rbvm_pkg::out_item_t            want;
    logic [rbvm_pkg::CFG_IDX_W-1:0] idx;
    rbvm_pkg::dim_t                 data;
  } dir_row_t;

  // Block ports; the inputs are driven to known values from time zero.
  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  rbvm_pkg::in_item_t             in_item   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  rbvm_pkg::out_item_t            out_item;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rbvm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  rbvm_pkg::dim_t                 cfg_data  = '0;

  // Predictor state: the open/solid map, which cells were loaded, and the grid size.
  bit                  cell_open   [rbvm_pkg::MAX_CELLS];
  bit                  cell_loaded [rbvm_pkg::MAX_CELLS];
  rbvm_pkg::dim_t      grid_dim    [3];
  rbvm_pkg::out_item_t pending_results [$];
  dir_row_t            dir_rows [$];

  int mismatch_count = 0;
  int tx_idle_pct    = 32;
  int rx_stall_pct   = 54;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;

  rbvm_pkg::dim_t phase_dims [NUM_PHASES][3] = '{
    '{7'd4,   7'd4,   7'd4},
    '{7'd1,   7'd1,   7'd1},
    '{7'd64,  7'd64,  7'd64},
    '{7'd2,   7'd3,   7'd5},
    '{7'd0,   7'd5,   7'd5},
    '{7'd127, 7'd127, 7'd127},
    '{7'd100, 7'd1,   7'd64},
    '{7'd7,   7'd64,  7'd2}
  };

  always #5 clk = ~clk;

  rigid_boundary_velocity_mask uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int clamp_dim(rbvm_pkg::dim_t d);
    return (d > rbvm_pkg::MAX_DIM) ? rbvm_pkg::MAX_DIM : int'(d);
  endfunction

  function automatic int cell_index(int x, int y, int z);
    return (x * rbvm_pkg::MAX_DIM + y) * rbvm_pkg::MAX_DIM + z;
  endfunction

  // Works out the result of one item and applies a load to the predicted map.
  function automatic rbvm_pkg::out_item_t mask_velocities(rbvm_pkg::in_item_t it);
    rbvm_pkg::out_item_t r;
    int                  nx, ny, nz, x, y, z, a;
    bit                  bad, here;
    nx = clamp_dim(grid_dim[0]);
    ny = clamp_dim(grid_dim[1]);
    nz = clamp_dim(grid_dim[2]);
    x  = int'(it.coord_x);
    y  = int'(it.coord_y);
    z  = int'(it.coord_z);
    a  = cell_index(x, y, z);
    bad = (x >= nx) || (y >= ny) || (z >= nz) || (a >= rbvm_pkg::MAX_CELLS);
    r = '0;
    r.bad_coord = bad;
    if (it.req_type == rbvm_pkg::REQ_LOAD) begin
      if (!bad) begin
        cell_open[a]   = it.open_cell;
        cell_loaded[a] = 1'b1;
      end
      return r;
    end
    r.vel_x_out = it.vel_x_in;
    r.vel_y_out = it.vel_y_in;
    r.vel_z_out = it.vel_z_in;
    if (!bad) begin
      here = cell_open[a];
      if (x + 1 < nx && !(here && cell_open[cell_index(x + 1, y, z)])) begin
        r.vel_x_out      = '0;
        r.zeroed_mask[0] = 1'b1;
      end
      if (y + 1 < ny && !(here && cell_open[cell_index(x, y + 1, z)])) begin
        r.vel_y_out      = '0;
        r.zeroed_mask[1] = 1'b1;
      end
      if (z + 1 < nz && !(here && cell_open[cell_index(x, y, z + 1)])) begin
        r.vel_z_out      = '0;
        r.zeroed_mask[2] = 1'b1;
      end
    end
    return r;
  endfunction

  // Address of the first map cell an apply at (x,y,z) would read before it was loaded,
  // or -1 when every cell it reads holds a loaded value.
  function automatic int unloaded_read(int x, int y, int z, int nx, int ny, int nz);
    if (!cell_loaded[cell_index(x, y, z)]) return cell_index(x, y, z);
    if (x + 1 < nx && !cell_loaded[cell_index(x + 1, y, z)]) return cell_index(x + 1, y, z);
    if (y + 1 < ny && !cell_loaded[cell_index(x, y + 1, z)]) return cell_index(x, y + 1, z);
    if (z + 1 < nz && !cell_loaded[cell_index(x, y, z + 1)]) return cell_index(x, y, z + 1);
    return -1;
  endfunction

  // Coordinates cluster near both ends of each axis so that the map fills quickly.
  function automatic int pick_coord(int n);
    if (n <= 4) return $urandom_range(0, n - 1);
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 3);
    return $urandom_range(n - 4, n - 1);
  endfunction

  function automatic rbvm_pkg::vel_t random_velocity();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic rbvm_pkg::in_item_t mk_item(logic req, int x, int y, int z,
                                                 logic open_bit, rbvm_pkg::vel_t vx,
                                                 rbvm_pkg::vel_t vy, rbvm_pkg::vel_t vz);
    rbvm_pkg::in_item_t it;
    it.req_type  = req;
    it.coord_x   = rbvm_pkg::coord_t'(x);
    it.coord_y   = rbvm_pkg::coord_t'(y);
    it.coord_z   = rbvm_pkg::coord_t'(z);
    it.open_cell = open_bit;
    it.vel_x_in  = vx;
    it.vel_y_in  = vy;
    it.vel_z_in  = vz;
    return it;
  endfunction

  function automatic rbvm_pkg::out_item_t mk_out(rbvm_pkg::vel_t vx, rbvm_pkg::vel_t vy,
                                                 rbvm_pkg::vel_t vz, logic [2:0] mask,
                                                 logic bad);
    rbvm_pkg::out_item_t r;
    r.vel_x_out   = vx;
    r.vel_y_out   = vy;
    r.vel_z_out   = vz;
    r.zeroed_mask = mask;
    r.bad_coord   = bad;
    return r;
  endfunction

  function automatic dir_row_t item_row(rbvm_pkg::in_item_t it, bit typed,
                                        rbvm_pkg::out_item_t want);
    dir_row_t row;
    row.kind  = ROW_ITEM;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    row.idx   = '0;
    row.data  = '0;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [rbvm_pkg::CFG_IDX_W-1:0] idx,
                                       rbvm_pkg::dim_t data);
    dir_row_t row;
    row.kind  = ROW_CFG;
    row.item  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    row.idx   = idx;
    row.data  = data;
    return row;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // One random item: mostly loads and applies on loaded cells, some with bad coordinates.
  // An apply that would read an unloaded cell becomes a load of that cell instead.
  function automatic rbvm_pkg::in_item_t next_random_item();
    rbvm_pkg::in_item_t it;
    int                 lim [3];
    int                 r, axis, miss, x, y, z;
    bit                 good_ok, bad_ok;
    lim[0] = clamp_dim(grid_dim[0]);
    lim[1] = clamp_dim(grid_dim[1]);
    lim[2] = clamp_dim(grid_dim[2]);
    good_ok = (lim[0] > 0) && (lim[1] > 0) && (lim[2] > 0);
    bad_ok  = (lim[0] < rbvm_pkg::MAX_DIM) || (lim[1] < rbvm_pkg::MAX_DIM) ||
              (lim[2] < rbvm_pkg::MAX_DIM);
    it = mk_item(1'($urandom_range(0, 1)), 0, 0, 0, ($urandom_range(0, 3) != 0),
                 random_velocity(), random_velocity(), random_velocity());
    r = $urandom_range(0, 99);
    if (!good_ok || (bad_ok && r < 12)) begin
      it.coord_x = rbvm_pkg::coord_t'($urandom_range(0, 63));
      it.coord_y = rbvm_pkg::coord_t'($urandom_range(0, 63));
      it.coord_z = rbvm_pkg::coord_t'($urandom_range(0, 63));
      do axis = $urandom_range(0, 2); while (lim[axis] >= rbvm_pkg::MAX_DIM);
      case (axis)
        0:       it.coord_x = rbvm_pkg::coord_t'($urandom_range(lim[0], 63));
        1:       it.coord_y = rbvm_pkg::coord_t'($urandom_range(lim[1], 63));
        default: it.coord_z = rbvm_pkg::coord_t'($urandom_range(lim[2], 63));
      endcase
      return it;
    end
    x = pick_coord(lim[0]);
    y = pick_coord(lim[1]);
    z = pick_coord(lim[2]);
    if (r < 45) begin
      it.req_type = rbvm_pkg::REQ_LOAD;
    end else begin
      it.req_type = rbvm_pkg::REQ_APPLY;
      miss = unloaded_read(x, y, z, lim[0], lim[1], lim[2]);
      if (miss >= 0) begin
        it.req_type = rbvm_pkg::REQ_LOAD;
        x = miss / (rbvm_pkg::MAX_DIM * rbvm_pkg::MAX_DIM);
        y = (miss / rbvm_pkg::MAX_DIM) % rbvm_pkg::MAX_DIM;
        z = miss % rbvm_pkg::MAX_DIM;
      end
    end
    it.coord_x = rbvm_pkg::coord_t'(x);
    it.coord_y = rbvm_pkg::coord_t'(y);
    it.coord_z = rbvm_pkg::coord_t'(z);
    return it;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch on %s: expected %h, got %h", what, want, got);
    mismatch_count++;
  endtask

  // Offers one item after a random gap and records its expected result on acceptance.
  task automatic send_item(rbvm_pkg::in_item_t it, bit typed, rbvm_pkg::out_item_t want);
    rbvm_pkg::out_item_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    predicted = mask_velocities(it);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic stop_and_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [rbvm_pkg::CFG_IDX_W-1:0] idx, rbvm_pkg::dim_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rbvm_pkg::REG_DIM_X: grid_dim[0] = val;
      rbvm_pkg::REG_DIM_Y: grid_dim[1] = val;
      rbvm_pkg::REG_DIM_Z: grid_dim[2] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Each accepted result is compared field by field with the oldest expectation.
  always @(posedge clk) begin : result_check
    rbvm_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected item", '0, out_item.vel_x_out);
      end else begin
        want = pending_results.pop_front();
        if (out_item.vel_x_out !== want.vel_x_out)
          flag_mismatch("vel_x_out", want.vel_x_out, out_item.vel_x_out);
        if (out_item.vel_y_out !== want.vel_y_out)
          flag_mismatch("vel_y_out", want.vel_y_out, out_item.vel_y_out);
        if (out_item.vel_z_out !== want.vel_z_out)
          flag_mismatch("vel_z_out", want.vel_z_out, out_item.vel_z_out);
        if (out_item.zeroed_mask !== want.zeroed_mask)
          flag_mismatch("zeroed_mask", 32'(want.zeroed_mask), 32'(out_item.zeroed_mask));
        if (out_item.bad_coord !== want.bad_coord)
          flag_mismatch("bad_coord", 32'(want.bad_coord), 32'(out_item.bad_coord));
      end
    end
  end

  // The run is cut off if it takes far longer than the slowest correct one.
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int sent;
    grid_dim[0] = rbvm_pkg::DIM_RESET;
    grid_dim[1] = rbvm_pkg::DIM_RESET;
    grid_dim[2] = rbvm_pkg::DIM_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: reset size, solid and open cells, last planes, bad coordinates,
    // zero and saturated sizes, a dropped load and an ignored register index.
    add_row(item_row(mk_item(rbvm_pkg::REQ_LOAD, 0, 0, 0, 1'b1, '1, '1, '1), 1'b1,
                     mk_out('0, '0, '0, 3'd0, 1'b0)));
    add_row(item_row(mk_item(rbvm_pkg::REQ_LOAD, 1, 0, 0, 1'b1, '0, '0, '0), 1'b1,
                     mk_out('0, '0, '0, 3'd0, 1'b0)));
    add_row(item_row(mk_item(rbvm_pkg::REQ_LOAD, 0, 1, 0, 1'b1, '0, '0, '0), 1'b1,
                     mk_out('0, '0, '0, 3'd0, 1'b0)));
    add_row(item_row(mk_item(rbvm_pkg::REQ_LOAD, 0, 0, 1, 1'b0, '0, '0, '0), 1'b1,
                     mk_out('0, '0, '0, 3'd0, 1'b0)));
    add_row(item_row(mk_item(rbvm_pkg::REQ_APPLY, 0, 0, 0, 1'b0, 32'hFFFF_FFFF,
                             32'h7F80_0000, 32'h8000_0000), 1'b0, '0));
    add_row(item_row(mk_item(rbvm_pkg::REQ_LOAD, 63, 63, 63, 1'b0, '1, '1, '1), 1'b1,
                     mk_out('0, '0, '0, 3'd0, 1'b0)));
    add_row(item_row(mk_item(rbvm_pkg::REQ_APPLY, 63, 63, 63, 1'b1, 32'h1234_5678,
                             32'h9ABC_DEF0, 32'h0F0F_0F0F), 1'b0, '0));
    add_row(item_row(mk_item(rbvm_pkg::REQ_LOAD, 62, 63, 63, 1'b1, '0, '0, '0), 1'b1,
                     mk_out('0, '0, '0, 3'd0, 1'b0)));
    add_row(item_row(mk_item(rbvm_pkg::REQ_APPLY, 62, 63, 63, 1'b0, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0));
    add_row(item_row(mk_item(rbvm_pkg::REQ_LOAD, 0, 0, 0, 1'b0, '0, '0, '0), 1'b1,
                     mk_out('0, '0, '0, 3'd0, 1'b0)));
    add_row(item_row(mk_item(rbvm_pkg::REQ_APPLY, 0, 0, 0, 1'b1, 32'h3F80_0000,
                             32'hBF80_0000, 32'h0000_0001), 1'b0, '0));
    add_row(cfg_row(rbvm_pkg::REG_DIM_X, 7'd2));
    add_row(item_row(mk_item(rbvm_pkg::REQ_LOAD, 2, 0, 0, 1'b1, '0, '0, '0), 1'b1,
                     mk_out('0, '0, '0, 3'd0, 1'b1)));
    add_row(item_row(mk_item(rbvm_pkg::REQ_APPLY, 5, 1, 0, 1'b1, 32'hA5A5_A5A5,
                             32'h5A5A_5A5A, 32'hFFFF_0000), 1'b1,
                     mk_out(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_0000, 3'd0, 1'b1)));
    add_row(cfg_row(rbvm_pkg::REG_DIM_Y, 7'd0));
    add_row(item_row(mk_item(rbvm_pkg::REQ_APPLY, 0, 0, 0, 1'b0, 32'hDEAD_BEEF,
                             32'h0000_0000, 32'hFFFF_FFFF), 1'b1,
                     mk_out(32'hDEAD_BEEF, 32'h0000_0000, 32'hFFFF_FFFF, 3'd0, 1'b1)));
    add_row(item_row(mk_item(rbvm_pkg::REQ_LOAD, 0, 0, 0, 1'b1, '0, '0, '0), 1'b1,
                     mk_out('0, '0, '0, 3'd0, 1'b1)));
    add_row(cfg_row(rbvm_pkg::REG_DIM_Y, 7'd127));
    add_row(cfg_row(rbvm_pkg::REG_DIM_X, 7'd1));
    add_row(item_row(mk_item(rbvm_pkg::REQ_APPLY, 0, 0, 0, 1'b1, 32'h1111_1111,
                             32'h2222_2222, 32'h3333_3333), 1'b0, '0));
    add_row(cfg_row(2'd3, 7'd5));
    add_row(cfg_row(rbvm_pkg::REG_DIM_X, 7'd64));
    add_row(cfg_row(rbvm_pkg::REG_DIM_Y, 7'd64));
    add_row(cfg_row(rbvm_pkg::REG_DIM_Z, 7'd64));
    add_row(item_row(mk_item(rbvm_pkg::REQ_APPLY, 0, 0, 0, 1'b1, '0, '0, '0), 1'b0, '0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        stop_and_drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random part: one grid size per phase, idling pattern changing with the item count.
    for (int p = 0; p < NUM_PHASES; p++) begin
      stop_and_drain();
      write_reg(rbvm_pkg::REG_DIM_X, phase_dims[p][0]);
      write_reg(rbvm_pkg::REG_DIM_Y, phase_dims[p][1]);
      write_reg(rbvm_pkg::REG_DIM_Z, phase_dims[p][2]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sent = p * ITEMS_PER_PHASE + n;
        if (sent == 350) begin
          tx_idle_pct  = 54;
          rx_stall_pct = 32;
        end
        if (sent == 700) begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        // A long receiver hold-off fills the block while the sender keeps offering.
        if (sent % 350 == 100) hold_requests++;
        // The sender also pauses once mid-phase until everything is back.
        if (sent == 220) stop_and_drain();
        send_item(next_random_item(), 1'b0, '0);
      end
    end

    stop_and_drain();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("missing item", 32'(pending_results.size()), '0);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/rbvm_pkg.sv
design/rbvm_map.sv
design/rigid_boundary_velocity_mask.sv
design/rbvm_checker.sv
verif/rigid_boundary_velocity_mask_tb.sv
